### src/ged_pkg.sv
// ----------------------------------------------------------------------------
// ged_pkg
// Shared widths, register indexes and reset values of the gradient edge
// detector.
// ----------------------------------------------------------------------------
package ged_pkg;

   localparam int MAG_W      = 9;   // magnitude field
   localparam int COORD_W    = 10;  // out_row / out_col fields
   localparam int COUNT_W    = 11;  // row_count / column_count registers
   localparam int THR_W      = 9;   // edge_threshold register
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

   localparam logic [COUNT_W-1:0] ROW_COUNT_RST      = 11'd480;
   localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST   = 11'd640;
   localparam logic [THR_W-1:0]   EDGE_THRESHOLD_RST = 9'd25;

   localparam logic [MAG_W-1:0] MAG_MAX = 9'd511;

endpackage

### src/ged_if.sv
// ----------------------------------------------------------------------------
// ged_if
// Valid/ready channels of the gradient edge detector: pixel requests,
// result responses and register writes.
// ----------------------------------------------------------------------------
interface ged_req_if #(parameter int PIX_W = 8);
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface ged_rsp_if;
   import ged_pkg::*;

   logic               valid;
   logic               ready;
   logic [MAG_W-1:0]   magnitude;
   logic               is_edge;
   logic [COORD_W-1:0] out_row;
   logic [COORD_W-1:0] out_col;
   logic               last;

   modport source (output valid, output magnitude, output is_edge, output out_row,
                   output out_col, output last, input ready);
   modport sink   (input valid, input magnitude, input is_edge, input out_row,
                   input out_col, input last, output ready);
endinterface

interface ged_csr_if;
   import ged_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/gradient_edge_detector.sv
// ----------------------------------------------------------------------------
// gradient_edge_detector
// Forward-difference gradient magnitude and edge flag over a raster pixel stream,
// with a one-row line memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus : pixels in raster order, one per transaction.
//   rsp_bus : results {magnitude, is_edge, out_row, out_col, last}. A pixel
//             of row i > 0 yields the result of pixel (i-1, col). In the last
//             row a pixel also yields (last, col-1), and the final pixel of
//             the frame yields itself with last = 1. Up to three results per
//             pixel, in that order.
//   csr_bus : register writes (0 row_count, 1 column_count, 2 edge_threshold);
//             a write to one of these restarts the frame at row 0, column 0.
//             Write only while the block is idle. Always ready.
// Timing:
//   One pixel at a time. With an open output a pixel runs from its accept
//   to the next accept through the accept state, two reads of the single-port
//   line memory (pixel above and above-right), one square stage, a state that
//   starts the root, the bit-serial square root, then one state per result
//   slot, each taken even when the slot is unused. The previous-row result is
//   loaded into the result register in S_OUT1. The result register lets the
//   next pixel be accepted while the last result of the previous one still
//   waits; a stalled receiver holds the block at the next result it must hand
//   over.
// Reset:
//   Registers return to 480 x 640, threshold 25, position (0, 0). The line
//   memory is not cleared; reads of unwritten entries go unused.
// ----------------------------------------------------------------------------
module gradient_edge_detector #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   ged_req_if.sink   req_bus,
   ged_rsp_if.source rsp_bus,
   ged_csr_if.sink   csr_bus
);

   import ged_pkg::*;

   localparam int RW     = $clog2(MAX_ROWS + 1);   // row index / count
   localparam int CW     = $clog2(MAX_COLS + 1);   // column index / count
   localparam int AW     = $clog2(MAX_COLS);       // line memory address
   localparam int PB     = PIXEL_BITS;
   localparam int ROOT_W = PB + 1;
   localparam int SQ_W   = 2 * PB;
   localparam int SUM_W  = 2 * PB + 1;
   localparam int CMP_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

   // sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_RDX  = 4'd1;   // read pixel above
   localparam logic [ST_W-1:0] S_RDA  = 4'd2;   // read pixel above-right
   localparam logic [ST_W-1:0] S_MUL  = 4'd3;   // squares, line memory write
   localparam logic [ST_W-1:0] S_SUM  = 4'd4;   // start square root
   localparam logic [ST_W-1:0] S_ROOT = 4'd5;
   localparam logic [ST_W-1:0] S_OUT1 = 4'd6;   // previous-row result
   localparam logic [ST_W-1:0] S_OUT2 = 4'd7;   // last-row, column to the left
   localparam logic [ST_W-1:0] S_OUT3 = 4'd8;   // final pixel of frame

   // ---------------- configuration ----------------
   logic [COUNT_W-1:0] row_count_ff, row_count_in;
   logic [COUNT_W-1:0] column_count_ff, column_count_in;
   logic [THR_W-1:0]   edge_threshold_ff, edge_threshold_in;
   logic               csr_restart;

   // ---------------- control ----------------
   logic [ST_W-1:0] state_ff, state_in;
   logic [RW-1:0]   row_idx_ff, row_idx_in;
   logic [CW-1:0]   col_idx_ff, col_idx_in;
   logic [PB-1:0]   prior_pixel_ff, prior_pixel_in;

   // ---------------- per-pixel work registers ----------------
   logic [PB-1:0]     pix_ff, pix_in;
   logic [PB-1:0]     prv_ff, prv_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic              has1_ff, has1_in;
   logic              has2_ff, has2_in;
   logic              has3_ff, has3_in;
   logic              mirror_ff, mirror_in;
   logic [PB-1:0]     x_ff, x_in;
   logic [SQ_W-1:0]   sq_a_ff, sq_a_in;
   logic [SQ_W-1:0]   sq_b_ff, sq_b_in;
   logic [ROOT_W-1:0] mag1_ff, mag1_in;

   // ---------------- result register ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]   rsp_mag_ff, rsp_mag_in;
   logic               rsp_edge_ff, rsp_edge_in;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic               rsp_last_ff, rsp_last_in;

   // ---------------- line memory ----------------
   logic [PB-1:0] line_mem [MAX_COLS];
   logic [PB-1:0] mem_q_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_rd;
   logic          mem_wr;

   // ---------------- combinational helpers ----------------
   logic [RW-1:0]   rows_eff;
   logic [CW-1:0]   cols_eff;
   logic [RW-1:0]   i_cur;
   logic [CW-1:0]   j_cur;
   logic [RW:0]     i_inc;
   logic [CW:0]     j_inc;
   logic            last_row;
   logic            col_end;
   logic            row_end;
   logic            req_take;
   logic [CW:0]     col_plus;
   logic [PB-1:0]   a_val;
   logic [PB-1:0]   diff_a;
   logic [PB-1:0]   diff_b;
   logic [PB-1:0]   diff_c;
   logic [SUM_W-1:0] sq_sum;
   logic [RW-1:0]   row_minus;
   logic [CW-1:0]   col_minus;
   logic            slot_free;
   logic            load;
   logic [CMP_W-1:0] ld_root;
   logic [COORD_W-1:0] ld_row;
   logic [COORD_W-1:0] ld_col;
   logic            ld_last;

   logic              sqrt_start;
   logic              sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;

   // counts of 0 act as 1, counts above the maximum act as the maximum
   always_comb begin
      if (row_count_ff == '0)
         rows_eff = RW'(1);
      else if (32'(row_count_ff) > 32'(MAX_ROWS))
         rows_eff = RW'(MAX_ROWS);
      else
         rows_eff = RW'(row_count_ff);
      if (column_count_ff == '0)
         cols_eff = CW'(1);
      else if (32'(column_count_ff) > 32'(MAX_COLS))
         cols_eff = CW'(MAX_COLS);
      else
         cols_eff = CW'(column_count_ff);
   end

   assign i_cur    = (row_idx_ff >= rows_eff) ? '0 : row_idx_ff;
   assign j_cur    = (col_idx_ff >= cols_eff) ? '0 : col_idx_ff;
   assign i_inc    = {1'b0, i_cur} + 1'b1;
   assign j_inc    = {1'b0, j_cur} + 1'b1;
   // last-row test uses the raw row index
   assign last_row = (({1'b0, row_idx_ff} + 1'b1) == {1'b0, rows_eff});
   assign col_end  = (j_inc >= {1'b0, cols_eff});
   assign row_end  = (i_inc >= {1'b0, rows_eff});

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && (state_ff == S_IDLE);

   assign csr_bus.ready = 1'b1;

   // line memory port: address above in S_RDX, above-right in S_RDA (above at the last column)
   assign col_plus = {1'b0, cur_col_ff} + 1'b1;
   assign mem_addr = (state_ff == S_RDA && !mirror_ff) ? col_plus[AW-1:0]
                                                       : cur_col_ff[AW-1:0];
   assign mem_rd   = (state_ff == S_RDX) || (state_ff == S_RDA);
   assign mem_wr   = (state_ff == S_MUL);

   always_ff @(posedge clock) begin
      if (mem_wr)
         line_mem[mem_addr] <= pix_ff;
      if (mem_rd)
         mem_q_ff <= line_mem[mem_addr];
   end

   // gradient terms
   assign a_val  = mirror_ff ? x_ff : mem_q_ff;
   assign diff_a = (x_ff >= a_val) ? x_ff - a_val : a_val - x_ff;
   assign diff_b = (x_ff >= pix_ff) ? x_ff - pix_ff : pix_ff - x_ff;
   // last-row result: only the horizontal term is nonzero, so no root needed
   assign diff_c = (prv_ff >= pix_ff) ? prv_ff - pix_ff : pix_ff - prv_ff;
   assign sq_sum = SUM_W'(sq_a_ff) + SUM_W'(sq_b_ff);

   assign sqrt_start = (state_ff == S_SUM);

   ged_isqrt #(
      .ROOT_W (ROOT_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ((2 * ROOT_W)'(sq_sum)),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign row_minus = cur_row_ff - 1'b1;
   assign col_minus = cur_col_ff - 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // ---------------- next-state logic ----------------
   always_comb begin
      state_in          = state_ff;
      row_count_in      = row_count_ff;
      column_count_in   = column_count_ff;
      edge_threshold_in = edge_threshold_ff;
      row_idx_in        = row_idx_ff;
      col_idx_in        = col_idx_ff;
      prior_pixel_in    = prior_pixel_ff;
      pix_in            = pix_ff;
      prv_in            = prv_ff;
      cur_row_in        = cur_row_ff;
      cur_col_in        = cur_col_ff;
      has1_in           = has1_ff;
      has2_in           = has2_ff;
      has3_in           = has3_ff;
      mirror_in         = mirror_ff;
      x_in              = x_ff;
      sq_a_in           = sq_a_ff;
      sq_b_in           = sq_b_ff;
      mag1_in           = mag1_ff;
      csr_restart       = 1'b0;
      load              = 1'b0;
      ld_root           = '0;
      ld_row            = COORD_W'(cur_row_ff);
      ld_col            = COORD_W'(cur_col_ff);
      ld_last           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pix_in         = req_bus.pixel;
               prv_in         = prior_pixel_ff;
               prior_pixel_in = req_bus.pixel;
               cur_row_in     = i_cur;
               cur_col_in     = j_cur;
               has1_in        = (i_cur != '0);
               has2_in        = last_row && (j_cur != '0);
               has3_in        = last_row && col_end;
               mirror_in      = col_end;
               if (col_end) begin
                  col_idx_in = '0;
                  row_idx_in = row_end ? '0 : i_inc[RW-1:0];
               end else begin
                  col_idx_in = j_inc[CW-1:0];
                  row_idx_in = i_cur;
               end
               state_in = S_RDX;
            end
         end
         S_RDX: state_in = S_RDA;
         S_RDA: begin
            x_in     = mem_q_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            sq_a_in  = SQ_W'(diff_a) * SQ_W'(diff_a);
            sq_b_in  = SQ_W'(diff_b) * SQ_W'(diff_b);
            state_in = S_SUM;
         end
         S_SUM: state_in = S_ROOT;
         S_ROOT: begin
            if (sqrt_done) begin
               mag1_in  = sqrt_root;
               state_in = S_OUT1;
            end
         end
         S_OUT1: begin
            ld_root = CMP_W'(mag1_ff);
            ld_row  = COORD_W'(row_minus);
            if (!has1_ff)
               state_in = S_OUT2;
            else if (slot_free) begin
               load     = 1'b1;
               state_in = S_OUT2;
            end
         end
         S_OUT2: begin
            ld_root = CMP_W'(diff_c);
            ld_col  = COORD_W'(col_minus);
            if (!has2_ff)
               state_in = S_OUT3;
            else if (slot_free) begin
               load     = 1'b1;
               state_in = S_OUT3;
            end
         end
         S_OUT3: begin
            ld_last = 1'b1;
            if (!has3_ff)
               state_in = S_IDLE;
            else if (slot_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // writes to the three registers restart the frame
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_ROW_COUNT: begin
               row_count_in = csr_bus.data;
               csr_restart  = 1'b1;
            end
            REG_COLUMN_COUNT: begin
               column_count_in = csr_bus.data;
               csr_restart     = 1'b1;
            end
            REG_EDGE_THRESHOLD: begin
               edge_threshold_in = csr_bus.data[THR_W-1:0];
               csr_restart       = 1'b1;
            end
            default: csr_restart = 1'b0;
         endcase
      end
      if (csr_restart) begin
         row_idx_in = '0;
         col_idx_in = '0;
      end
   end

   // result register: saturated magnitude, edge flag on the full value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_mag_in   = rsp_mag_ff;
      rsp_edge_in  = rsp_edge_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = (ld_root > CMP_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(ld_root);
         rsp_edge_in  = (ld_root > CMP_W'(edge_threshold_ff));
         rsp_row_in   = ld_row;
         rsp_col_in   = ld_col;
         rsp_last_in  = ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         row_count_ff      <= ROW_COUNT_RST;
         column_count_ff   <= COLUMN_COUNT_RST;
         edge_threshold_ff <= EDGE_THRESHOLD_RST;
         row_idx_ff        <= '0;
         col_idx_ff        <= '0;
         prior_pixel_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         row_count_ff      <= row_count_in;
         column_count_ff   <= column_count_in;
         edge_threshold_ff <= edge_threshold_in;
         row_idx_ff        <= row_idx_in;
         col_idx_ff        <= col_idx_in;
         prior_pixel_ff    <= prior_pixel_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      pix_ff      <= pix_in;
      prv_ff      <= prv_in;
      cur_row_ff  <= cur_row_in;
      cur_col_ff  <= cur_col_in;
      has1_ff     <= has1_in;
      has2_ff     <= has2_in;
      has3_ff     <= has3_in;
      mirror_ff   <= mirror_in;
      x_ff        <= x_in;
      sq_a_ff     <= sq_a_in;
      sq_b_ff     <= sq_b_in;
      mag1_ff     <= mag1_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.magnitude = rsp_mag_ff;
   assign rsp_bus.is_edge   = rsp_edge_ff;
   assign rsp_bus.out_row   = rsp_row_ff;
   assign rsp_bus.out_col   = rsp_col_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule

### src/ged_isqrt.sv
// ----------------------------------------------------------------------------
// ged_isqrt
// Restoring integer square root, one root bit per cycle. Pulses done for
// one cycle when root holds floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module ged_isqrt #(
   parameter int ROOT_W = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*ROOT_W-1:0] radicand,
   output logic                done,
   output logic [ROOT_W-1:0]   root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [ROOT_W:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [ROOT_W+2:0]   rem_sh;
   logic [ROOT_W+2:0]   trial;
   logic [ROOT_W+2:0]   diff;
   logic                fits;

   assign rem_sh = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign fits   = (rem_sh >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*ROOT_W-3:0], 2'b00};
         rem_in  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
